/* sv/mbet_pkg.sv */
// mbet_pkg: shared types and constants for the escape-time unit
// used by mbet_cell and mandelbrot_escape_time_unit; depends on nothing
package mbet_pkg;

  // iteration counter and limit register width
  localparam int unsigned ITER_WIDTH   = 16;
  // escape bound register width, unsigned with the coordinate fraction
  localparam int unsigned RADIUS_WIDTH = 31;
  // number of iteration cells in the ring
  localparam int unsigned NUM_CELLS    = 2;

  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned CFG_DATA_WIDTH = 31;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_ITER   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ESC_RADIUS = 2'd1;

  localparam logic [ITER_WIDTH-1:0]   MAX_ITER_RESET   = 16'd256;
  localparam logic [RADIUS_WIDTH-1:0] ESC_RADIUS_RESET = 31'd67108864;

  localparam logic [31:0] PIXEL_BASE = 32'hFF00_0000;

  // control word handed from cell to cell with the z value
  typedef struct packed {
    logic                  valid;
    logic [ITER_WIDTH-1:0] round;
  } iter_ctrl_t;

endpackage

/* sv/mbet_cell.sv */
// mbet_cell: one iteration cell of the ring, two register stages per round
// stage one forms the exact squares and cross product, stage two tests and updates z
// depends on mbet_pkg
module mbet_cell import mbet_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 24,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iter_ctrl_t                     ctrl_i,
  input  logic signed [COORD_WIDTH-1:0]  x_i,
  input  logic signed [COORD_WIDTH-1:0]  y_i,
  input  logic signed [COORD_WIDTH-1:0]  cr_i,
  input  logic signed [COORD_WIDTH-1:0]  ci_i,
  input  logic [ITER_WIDTH-1:0]          limit_i,
  input  logic [RADIUS_WIDTH-1:0]        radius_i,
  output iter_ctrl_t                     ctrl_o,
  output logic signed [COORD_WIDTH-1:0]  x_o,
  output logic signed [COORD_WIDTH-1:0]  y_o,
  output logic                           fin_o,
  output logic [ITER_WIDTH-1:0]          fin_count_o
);

  localparam int unsigned PW    = 2 * COORD_WIDTH;
  localparam int unsigned DW    = PW + 1;
  localparam int unsigned BW    = RADIUS_WIDTH + FRAC_BITS;
  localparam int unsigned CMP_W = (PW > BW) ? PW : BW;

  // stage one: products
  logic [COORD_WIDTH-1:0] ax, ay;
  logic [PW-1:0]          xx_d, yy_d, xx_q, yy_q;
  logic signed [PW-1:0]   xy_d, xy_q;
  iter_ctrl_t             ctrl1_q;

  assign ax   = x_i[COORD_WIDTH-1] ? (~$unsigned(x_i) + 1'b1) : $unsigned(x_i);
  assign ay   = y_i[COORD_WIDTH-1] ? (~$unsigned(y_i) + 1'b1) : $unsigned(y_i);
  assign xx_d = PW'(ax) * PW'(ax);
  assign yy_d = PW'(ay) * PW'(ay);
  assign xy_d = PW'(x_i) * PW'(y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= xx_d;
    yy_q <= yy_d;
    xy_q <= xy_d;
  end

  // stage two: escape test and update
  logic [PW-1:0]          mag_sq;
  logic [CMP_W-1:0]       mag_ext, bound;
  logic                   at_limit, escaped, fin;
  logic signed [DW-1:0]   diff, nx_w, ny_w;
  logic signed [COORD_WIDTH-1:0] x_d, y_d, x_q, y_q;
  iter_ctrl_t             ctrl_d, ctrl_q;

  assign mag_sq   = xx_q + yy_q;
  assign mag_ext  = CMP_W'(mag_sq);
  assign bound    = CMP_W'(radius_i) << FRAC_BITS;
  assign at_limit = (ctrl1_q.round == limit_i);
  assign escaped  = (mag_ext >= bound);
  assign fin      = ctrl1_q.valid && (at_limit || escaped);

  assign diff = $signed({1'b0, xx_q}) - $signed({1'b0, yy_q});
  assign nx_w = (diff >>> FRAC_BITS) + DW'(cr_i);
  assign ny_w = (DW'(xy_q) >>> (FRAC_BITS - 1)) + DW'(ci_i);

  // clamp to the coordinate range when the upper bits are not all sign
  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [DW-1:0] v);
    logic [DW-COORD_WIDTH:0] top;
    top = v[DW-1:COORD_WIDTH-1];
    if ((top == '0) || (top == '1)) begin
      sat = v[COORD_WIDTH-1:0];
    end else if (v[DW-1]) begin
      sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  assign x_d          = sat(nx_w);
  assign y_d          = sat(ny_w);
  assign ctrl_d.valid = ctrl1_q.valid && !fin;
  assign ctrl_d.round = ctrl1_q.round + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign ctrl_o      = ctrl_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign fin_o       = fin;
  // reaching the limit reports zero, whether or not the point escapes in that round
  assign fin_count_o = at_limit ? '0 : ctrl1_q.round;

endmodule

/* sv/mandelbrot_escape_time_unit.sv */
// mandelbrot_escape_time_unit: escape-time count for one complex point
// top level, a ring of mbet_cell iteration cells; depends on mbet_pkg and mbet_cell
//
// usage:
//   a request is taken at a rising edge with start_i high and busy_o low; it
//   carries the point c in point_real_i / point_imag_i (signed fixed point)
//   busy_o stays high from that edge until the result strobe; the result
//   shows on escape_count_o / pixel_word_o as done_o goes high for exactly
//   one cycle, holds until the next result; the receiver cannot hold it off
//   the point travels around a ring of cells, each round passing a product
//   stage (the three exact products), then the test, update and clamp stage
//   done_o is registered from the finish flag of the cell that ends the
//   point, at the latest in the round whose number equals the iteration
//   limit; the next request is taken in the cycle done_o is high
//   the config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the iteration
//   limit and the escape bound; write it only while busy_o is low
//   reset clears the ring, drops busy_o and loads limit 256 and bound 4.0
module mandelbrot_escape_time_unit import mbet_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 24,
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_real_i,
  input  logic signed [COORD_WIDTH-1:0] point_imag_i,
  output logic                          done_o,
  output logic [COUNT_WIDTH-1:0]        escape_count_o,
  output logic [31:0]                   pixel_word_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_wdata_i
);

  logic [ITER_WIDTH-1:0]   max_iter_q;
  logic [RADIUS_WIDTH-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
      radius_q   <= ESC_RADIUS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_ITER:   max_iter_q <= cfg_wdata_i[ITER_WIDTH-1:0];
        REG_ESC_RADIUS: radius_q   <= cfg_wdata_i[RADIUS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic busy_q, done_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic signed [COORD_WIDTH-1:0] cr_q, ci_q;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cr_q <= point_real_i;
      ci_q <= point_imag_i;
    end
  end

  // ring wiring
  iter_ctrl_t                    ctrl_in  [NUM_CELLS];
  iter_ctrl_t                    ctrl_out [NUM_CELLS];
  logic signed [COORD_WIDTH-1:0] x_in  [NUM_CELLS];
  logic signed [COORD_WIDTH-1:0] y_in  [NUM_CELLS];
  logic signed [COORD_WIDTH-1:0] x_out [NUM_CELLS];
  logic signed [COORD_WIDTH-1:0] y_out [NUM_CELLS];
  logic                          fin   [NUM_CELLS];
  logic [ITER_WIDTH-1:0]         fin_count [NUM_CELLS];

  // a new request enters in place of the empty slot from the last cell
  always_comb begin
    if (accept) begin
      ctrl_in[0].valid = 1'b1;
      ctrl_in[0].round = '0;
      x_in[0]          = point_real_i;
      y_in[0]          = point_imag_i;
    end else begin
      ctrl_in[0] = ctrl_out[NUM_CELLS-1];
      x_in[0]    = x_out[NUM_CELLS-1];
      y_in[0]    = y_out[NUM_CELLS-1];
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign ctrl_in[k] = ctrl_out[k-1];
      assign x_in[k]    = x_out[k-1];
      assign y_in[k]    = y_out[k-1];
    end

    mbet_cell #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_in[k]),
      .x_i         (x_in[k]),
      .y_i         (y_in[k]),
      .cr_i        (cr_q),
      .ci_i        (ci_q),
      .limit_i     (max_iter_q),
      .radius_i    (radius_q),
      .ctrl_o      (ctrl_out[k]),
      .x_o         (x_out[k]),
      .y_o         (y_out[k]),
      .fin_o       (fin[k]),
      .fin_count_o (fin_count[k])
    );
  end

  // only one point is in the ring, so at most one cell finishes
  logic                  fin_any;
  logic [ITER_WIDTH-1:0] fin_sel;

  always_comb begin
    fin_any = 1'b0;
    fin_sel = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      if (fin[k]) begin
        fin_any = 1'b1;
        fin_sel = fin_count[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_any;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fin_any) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_any) begin
      count_q <= COUNT_WIDTH'(fin_sel);
    end
  end

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign escape_count_o = count_q;
  assign pixel_word_o   = PIXEL_BASE + 32'(count_q);

endmodule

/* verif/mandelbrot_escape_time_unit_tb.sv */
`timescale 1ns / 1ps
// mandelbrot_escape_time_unit_tb: self-checking bench for the escape-time unit
// holds a scoreboard class with its own escape-count predictor; depends on mbet_pkg and mandelbrot_escape_time_unit
module mandelbrot_escape_time_unit_tb;
  import mbet_pkg::*;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = 24;
  localparam longint COORD_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint COORD_LO = -COORD_HI - 1;

  // indexes the block must ignore
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED_B = 2'd3;

  class escape_scoreboard;
    typedef struct {
      logic [ITER_WIDTH-1:0] count;
      logic [31:0]           pixel;
    } escape_result_t;

    logic [ITER_WIDTH-1:0]   iter_limit;
    logic [RADIUS_WIDTH-1:0] radius_sq;
    escape_result_t          expected_results[$];
    int unsigned             checked;
    int unsigned             errors;

    function new();
      iter_limit = MAX_ITER_RESET;
      radius_sq  = ESC_RADIUS_RESET;
      checked    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_MAX_ITER: begin
          iter_limit = data[ITER_WIDTH-1:0];
        end
        REG_ESC_RADIUS: begin
          radius_sq = data[RADIUS_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic [ITER_WIDTH-1:0] escape_round_of(logic signed [COORD_W-1:0] re,
                                                    logic signed [COORD_W-1:0] im);
      longint            cr, ci, x, y, sq_x, sq_y, prod, nx, ny;
      longint unsigned   bound;
      int unsigned       n;
      cr = re;
      ci = im;
      x = cr;
      y = ci;
      bound = longint'(radius_sq) << FRAC_W;
      for (n = 0; n < iter_limit; n++) begin
        sq_x = x * x;
        sq_y = y * y;
        prod = x * y;
        // magnitude can reach 2^63, so the sum is taken unsigned
        if ($unsigned(sq_x) + $unsigned(sq_y) >= bound) return n[ITER_WIDTH-1:0];
        nx = ((sq_x - sq_y) >>> FRAC_W) + cr;
        ny = (prod >>> (FRAC_W - 1)) + ci;
        x = (nx > COORD_HI) ? COORD_HI : (nx < COORD_LO) ? COORD_LO : nx;
        y = (ny > COORD_HI) ? COORD_HI : (ny < COORD_LO) ? COORD_LO : ny;
      end
      // never escaped
      return '0;
    endfunction

    function void note_point(logic signed [COORD_W-1:0] re, logic signed [COORD_W-1:0] im);
      escape_result_t r;
      r.count = escape_round_of(re, im);
      r.pixel = PIXEL_BASE + 32'(r.count);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [ITER_WIDTH-1:0] count, logic [31:0] pixel);
      escape_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, got count %0d pixel %h",
                 $time, count, pixel);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (count !== want.count) begin
        errors++;
        $display("%0t: escape_count expected %0d got %0d", $time, want.count, count);
      end
      if (pixel !== want.pixel) begin
        errors++;
        $display("%0t: pixel_word expected %h got %h", $time, want.pixel, pixel);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic signed [COORD_W-1:0]   point_real_i;
  logic signed [COORD_W-1:0]   point_imag_i;
  logic                        done_o;
  logic [ITER_WIDTH-1:0]       escape_count_o;
  logic [31:0]                 pixel_word_o;
  logic                        cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]    cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata_i;

  escape_scoreboard sb = new();
  int unsigned      sender_idle_pct;
  int unsigned      reg_writes;

  mandelbrot_escape_time_unit #(
    .FRAC_BITS  (FRAC_W),
    .COORD_WIDTH(COORD_W),
    .COUNT_WIDTH(ITER_WIDTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .point_real_i  (point_real_i),
    .point_imag_i  (point_imag_i),
    .done_o        (done_o),
    .escape_count_o(escape_count_o),
    .pixel_word_o  (pixel_word_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(escape_count_o, pixel_word_o);
      if (start_i && !busy_o) sb.note_point(point_real_i, point_imag_i);
    end
  end

  function automatic logic signed [COORD_W-1:0] fix(real v);
    return $rtoi(v * 16777216.0);
  endfunction

  // offers one request; idle cycles put junk on the point ports with start low
  task automatic drive_point(input logic signed [COORD_W-1:0] re,
                             input logic signed [COORD_W-1:0] im);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
        start_i      = 1'b0;
        point_real_i = $urandom;
        point_imag_i = $urandom;
      end else begin
        start_i      = 1'b1;
        point_real_i = re;
        point_imag_i = im;
      end
      @(posedge clk_i);
      taken = start_i && !busy_o;
    end
  endtask

  // every request yields a result, so an empty queue and busy low mean idle
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    sb.set_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // limits stay small so the random part runs in reasonable time
  task automatic pick_setting();
    logic [CFG_DATA_WIDTH-1:0] data;
    data = CFG_DATA_WIDTH'($urandom);
    case ($urandom_range(4))
      0: data[ITER_WIDTH-1:0] = '0;
      1: data[ITER_WIDTH-1:0] = 16'd1;
      2: data[ITER_WIDTH-1:0] = 16'($urandom_range(2, 40));
      3: data[ITER_WIDTH-1:0] = MAX_ITER_RESET;
      default: data[ITER_WIDTH-1:0] = 16'($urandom_range(41, 300));
    endcase
    write_reg(REG_MAX_ITER, data);
    case ($urandom_range(4))
      0: data = '1;
      1: data = '0;
      2: data = ESC_RADIUS_RESET;
      3: data = CFG_DATA_WIDTH'($urandom);
      default: data = CFG_DATA_WIDTH'($urandom_range(0, 32'h1000_0000));
    endcase
    write_reg(REG_ESC_RADIUS, data);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, CFG_DATA_WIDTH'($urandom));
  endtask

  task automatic random_point(output logic signed [COORD_W-1:0] re,
                              output logic signed [COORD_W-1:0] im);
    case ($urandom_range(9))
      0, 1: begin
        re = $urandom;
        im = $urandom;
      end
      2, 3: begin
        re = $signed(COORD_W'($urandom)) >>> $urandom_range(31);
        im = $signed(COORD_W'($urandom)) >>> $urandom_range(31);
      end
      default: begin
        // window around the set: real -2.25..0.75, imag -1.5..1.5
        re = int'($urandom_range(0, 50331648)) - 37748736;
        im = int'($urandom_range(0, 50331648)) - 25165824;
      end
    endcase
  endtask

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic signed [COORD_W-1:0] re, im;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    point_real_i    = '0;
    point_imag_i    = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_MAX_ITER;
    cfg_wdata_i     = '0;
    sender_idle_pct = 0;
    reg_writes      = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limit and bound
    drive_point('0, '0);
    drive_point(fix(-2.0), '0);
    drive_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    drive_point(32'sh8000_0000, 32'sh8000_0000);
    drive_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    drive_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    drive_point(fix(0.25), '0);
    drive_point(fix(0.26), '0);
    drive_point(fix(-1.0), '0);
    drive_point('0, fix(1.0));
    drive_point(fix(1.0), fix(1.0));
    drive_point(fix(2.0) - 1, '0);
    drive_point(fix(-0.75), fix(0.1));

    // widest bound: first update overflows and clamps
    drain();
    write_reg(REG_ESC_RADIUS, '1);
    drive_point(fix(11.0), '0);
    drive_point(fix(7.8), fix(7.8));
    drive_point(fix(7.8), fix(-7.8));

    // zero bound escapes at once
    drain();
    write_reg(REG_ESC_RADIUS, '0);
    drive_point('0, '0);

    // zero limit with upper data bits set, then limits 1 and 2
    drain();
    write_reg(REG_ESC_RADIUS, ESC_RADIUS_RESET);
    write_reg(REG_MAX_ITER, 31'h7FFF_0000);
    drive_point(fix(1.0), fix(1.0));
    drain();
    write_reg(REG_MAX_ITER, 31'd1);
    drive_point(fix(1.0), fix(1.0));
    drain();
    write_reg(REG_MAX_ITER, 31'd2);
    drive_point(fix(1.0), fix(1.0));

    // largest limit, then writes to unused indexes that must change nothing
    drain();
    write_reg(REG_MAX_ITER, 31'h7FFF_FFFF);
    write_reg(REG_UNUSED_A, 31'd5);
    write_reg(REG_UNUSED_B, '0);
    drive_point('0, '0);
    drive_point(fix(0.26), '0);

    for (int chunk = 0; chunk < 13; chunk++) begin
      drain();
      pick_setting();
      sender_idle_pct = (chunk < 5) ? 35 : (chunk < 9) ? 71 : 0;
      repeat (50) begin
        random_point(re, im);
        drive_point(re, im);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("checked %0d escape counts over %0d register writes (limits 0..65535, bounds 0..max)",
             sb.checked, reg_writes);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* mandelbrot_escape_time_unit.f */
sv/mbet_pkg.sv
sv/mbet_cell.sv
sv/mandelbrot_escape_time_unit.sv
verif/mandelbrot_escape_time_unit_tb.sv
